[rtl/core/mrae_pkg.sv]
// ----------------------------------------------------------------------------
// mrae_pkg
// shared types and constants for the r-type alu execute core
// ----------------------------------------------------------------------------
package mrae_pkg;

    localparam int unsigned DATA_W  = 32;
    localparam int unsigned NUM_REG = 32;
    localparam int unsigned REG_W   = 5;
    localparam int unsigned OP_W    = 3;

    localparam logic [REG_W-1:0] REG_ZERO = '0;

    // operation codes
    typedef enum logic [OP_W-1:0] {
        OP_AND  = 3'd0,
        OP_OR   = 3'd1,
        OP_XOR  = 3'd2,
        OP_ADDU = 3'd3,
        OP_SLL  = 3'd4,
        OP_SLT  = 3'd5,
        OP_SRLV = 3'd6,
        OP_LOAD = 3'd7
    } t_op;

    // operands and controls handed to the alu
    typedef struct packed {
        t_op               op;
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
        logic [REG_W-1:0]  shamt;
        logic [DATA_W-1:0] load_value;
    } t_alu_req;

endpackage

[rtl/core/mrae_ram.sv]
// ----------------------------------------------------------------------------
// mrae_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module mrae_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // read returns old data on a same-address write
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/mrae_alu.sv]
// ----------------------------------------------------------------------------
// mrae_alu
// combinational r-type alu: logic ops, addu, shifts, load pass-through, signed set-less-than
// ----------------------------------------------------------------------------
module mrae_alu (
    input  mrae_pkg::t_alu_req          i_req,
    output logic [mrae_pkg::DATA_W-1:0] o_result
);

    import mrae_pkg::*;

    always_comb begin
        unique case (i_req.op)
            OP_AND:  o_result = i_req.a & i_req.b;
            OP_OR:   o_result = i_req.a | i_req.b;
            OP_XOR:  o_result = i_req.a ^ i_req.b;
            OP_ADDU: o_result = i_req.a + i_req.b;
            OP_SLL:  o_result = i_req.b << i_req.shamt;
            OP_SLT:  o_result = {{(DATA_W-1){1'b0}}, ($signed(i_req.a) < $signed(i_req.b))};
            OP_SRLV: o_result = i_req.b >> i_req.a[REG_W-1:0];
            OP_LOAD: o_result = i_req.load_value;
            default: o_result = '0;
        endcase
    end

endmodule

[rtl/core/mips_rtype_alu_execute_core.sv]
// ----------------------------------------------------------------------------
// mips_rtype_alu_execute_core
// r-type alu execute stage around a 32 x 32 register file held in ram
// ----------------------------------------------------------------------------
//
// channel  direction  handshake                 payload
// in       request    i_in_valid / o_in_ready   i_operation, i_instruction, i_load_value
// out      result     o_out_valid / i_out_ready o_dest_register, o_dest_value
//
// one request per cycle sustained while the output is not stalled; the ram
// reads at the accepting edge into the execute stage, and the execute result
// lands in the output register when that register is free
// a write in the same cycle as the next request's read is forwarded, so
// back-to-back dependent requests do not stall
// reset clears the per-register valid bits, so every register reads as zero
// at once; no clearing pass is needed
// a stalled output holds the execute stage, which in turn holds off input
//
module mips_rtype_alu_execute_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // request channel
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [mrae_pkg::OP_W-1:0]     i_operation,
    input  logic [mrae_pkg::DATA_W-1:0]   i_instruction,
    input  logic [mrae_pkg::DATA_W-1:0]   i_load_value,
    // result channel
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [mrae_pkg::REG_W-1:0]    o_dest_register,
    output logic [mrae_pkg::DATA_W-1:0]   o_dest_value
);

    import mrae_pkg::*;

    // instruction field decode
    logic [REG_W-1:0] in_rs;
    logic [REG_W-1:0] in_rt;
    logic [REG_W-1:0] in_rd;
    logic [REG_W-1:0] in_shamt;

    assign in_rs    = i_instruction[25:21];
    assign in_rt    = i_instruction[20:16];
    assign in_rd    = i_instruction[15:11];
    assign in_shamt = i_instruction[10:6];

    // execute stage registers
    logic              r_ex_valid;
    t_op               r_ex_op;
    logic [REG_W-1:0]  r_ex_rd;
    logic [REG_W-1:0]  r_ex_shamt;
    logic [DATA_W-1:0] r_ex_load;

    // operand forwarding and per-register valid bits
    logic              r_fwd_a;
    logic              r_fwd_b;
    logic [DATA_W-1:0] r_fwd_val;
    logic              r_vld_a;
    logic              r_vld_b;
    logic [NUM_REG-1:0] r_vld;
    logic [NUM_REG-1:0] n_vld;

    // output register
    logic              r_out_valid;
    logic [REG_W-1:0]  r_out_rd;
    logic [DATA_W-1:0] r_out_val;

    logic              ex_adv;
    logic              in_accept;
    logic              wr_en;
    logic [DATA_W-1:0] rdata_a;
    logic [DATA_W-1:0] rdata_b;
    logic [DATA_W-1:0] alu_res;
    logic [DATA_W-1:0] res_value;
    t_alu_req          alu_req;

    // execute moves into the output register when that register is free
    assign ex_adv     = !r_out_valid || i_out_ready;
    assign o_in_ready = !r_ex_valid || ex_adv;
    assign in_accept  = i_in_valid && o_in_ready;

    // register zero is never written and never marked valid
    assign wr_en = r_ex_valid && ex_adv && (r_ex_rd != REG_ZERO);

    // two copies of the register file, one per source operand
    mrae_ram #(
        .WIDTH (DATA_W),
        .DEPTH (NUM_REG)
    ) u_ram_rs (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_ex_rd),
        .i_wdata (alu_res),
        .i_re    (in_accept),
        .i_raddr (in_rs),
        .o_rdata (rdata_a)
    );

    mrae_ram #(
        .WIDTH (DATA_W),
        .DEPTH (NUM_REG)
    ) u_ram_rt (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_ex_rd),
        .i_wdata (alu_res),
        .i_re    (in_accept),
        .i_raddr (in_rt),
        .o_rdata (rdata_b)
    );

    // operand select: forwarded write, then ram data, else reset value zero
    always_comb begin
        alu_req.op         = r_ex_op;
        alu_req.shamt      = r_ex_shamt;
        alu_req.load_value = r_ex_load;
        priority if (r_fwd_a) begin
            alu_req.a = r_fwd_val;
        end else if (r_vld_a) begin
            alu_req.a = rdata_a;
        end else begin
            alu_req.a = '0;
        end
        priority if (r_fwd_b) begin
            alu_req.b = r_fwd_val;
        end else if (r_vld_b) begin
            alu_req.b = rdata_b;
        end else begin
            alu_req.b = '0;
        end
    end

    mrae_alu u_alu (
        .i_req    (alu_req),
        .o_result (alu_res)
    );

    // writes to register zero report zero
    assign res_value = (r_ex_rd == REG_ZERO) ? '0 : alu_res;

    always_comb begin
        n_vld = r_vld;
        if (wr_en) begin
            n_vld[r_ex_rd] = 1'b1;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ex_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_vld       <= '0;
            r_fwd_a     <= 1'b0;
            r_fwd_b     <= 1'b0;
        end else begin
            r_vld <= n_vld;
            if (o_in_ready) begin
                r_ex_valid <= i_in_valid;
            end
            if (ex_adv) begin
                r_out_valid <= r_ex_valid;
            end
            if (in_accept) begin
                // ram read misses a write landing at this same edge
                r_fwd_a <= wr_en && (in_rs == r_ex_rd);
                r_fwd_b <= wr_en && (in_rt == r_ex_rd);
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_ex_op    <= t_op'(i_operation);
            r_ex_rd    <= in_rd;
            r_ex_shamt <= in_shamt;
            r_ex_load  <= i_load_value;
            r_fwd_val  <= alu_res;
            r_vld_a    <= r_vld[in_rs];
            r_vld_b    <= r_vld[in_rt];
        end
        if (ex_adv && r_ex_valid) begin
            r_out_rd  <= r_ex_rd;
            r_out_val <= res_value;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_dest_register = r_out_rd;
    assign o_dest_value    = r_out_val;

    // register zero never becomes valid
    a_zero_never_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_vld[0])
        else $error("register zero marked valid");

    // a result for register zero carries zero
    a_zero_dest_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_rd == REG_ZERO)) |-> (r_out_val == '0))
        else $error("nonzero value reported for register zero");

    // forwarding only follows a write at the accepting edge
    a_fwd_after_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ex_valid && (r_fwd_a || r_fwd_b) && $past(in_accept)) |-> $past(wr_en))
        else $error("forward flag without a write");

    // an advancing execute item lands in the output register
    a_ex_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ex_valid && ex_adv) |=> r_out_valid)
        else $error("execute item lost");

    // a write marks its register valid
    a_write_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |=> r_vld[$past(r_ex_rd)])
        else $error("written register not marked valid");

endmodule
